// ----- src/ppbb_pkg.sv -----
`timescale 1ns / 1ps
package ppbb_pkg;

  localparam int CAPACITY = 1024;

  // Fixed field widths of the channels
  localparam int FUNC_W = 3;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 11;

  // Pointer holds 0..CAPACITY; store holds both sides
  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(2 * CAPACITY);
  localparam int DEPTH  = 2 * CAPACITY;
  localparam int CMP_W  = (PTR_W > CNT_W) ? PTR_W : CNT_W;

  localparam logic [FUNC_W-1:0] FN_PUT        = 3'd0;
  localparam logic [FUNC_W-1:0] FN_GET        = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK       = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE_OUT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE_IN  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR_OUT  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR_IN   = 3'd6;
  localparam logic [FUNC_W-1:0] FN_FLIP       = 3'd7;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             rd;
    logic             ok;
    logic [CNT_W-1:0] used_in;
    logic [CNT_W-1:0] used_out;
    logic [CNT_W-1:0] free_in;
  } step_res_t;

endpackage

// ----- src/ppbb_if.sv -----
`timescale 1ns / 1ps
interface ppbb_in_if;
  import ppbb_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] data_in;
  logic [CNT_W-1:0]  count;

  modport source (output valid, func, data_in, count, input ready);
  modport sink   (input valid, func, data_in, count, output ready);
endinterface

interface ppbb_out_if;
  import ppbb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              ok;
  logic [CNT_W-1:0]  used_in;
  logic [CNT_W-1:0]  used_out;
  logic [CNT_W-1:0]  free_in;

  modport source (output valid, data_out, ok, used_in, used_out, free_in, input ready);
  modport sink   (input valid, data_out, ok, used_in, used_out, free_in, output ready);
endinterface

// ----- src/ppbb_mem.sv -----
`timescale 1ns / 1ps
module ppbb_mem
  import ppbb_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    // read data holds while no read is issued
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/ppbb_ctrl.sv -----
`timescale 1ns / 1ps
module ppbb_ctrl
  import ppbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [FUNC_W-1:0] func,
  input  logic [DATA_W-1:0] data_in,
  input  logic [CNT_W-1:0]  count,
  output mem_req_t          req,
  output step_res_t         res
);

  logic [PTR_W-1:0] rp_r   [2];
  logic [PTR_W-1:0] wp_r   [2];
  logic [PTR_W-1:0] rp_nxt [2];
  logic [PTR_W-1:0] wp_nxt [2];
  logic             side_r;
  logic             side_nxt;

  logic             si;
  logic             so;
  logic [PTR_W-1:0] held_i;
  logic [PTR_W-1:0] held_o;
  logic [PTR_W-1:0] peek_pos;
  logic [CMP_W-1:0] cnt_x;
  logic [PTR_W-1:0] ui;
  logic [PTR_W-1:0] uo;
  logic             ok;
  logic             rd;

  function automatic logic [ADDR_W-1:0] store_idx(input logic side, input logic [PTR_W-1:0] pos);
    logic [ADDR_W-1:0] base;
    base = side ? ADDR_W'(CAPACITY) : '0;
    return base + ADDR_W'(pos);
  endfunction

  assign si       = side_r;
  assign so       = ~side_r;
  assign held_i   = wp_r[si] - rp_r[si];
  assign held_o   = wp_r[so] - rp_r[so];
  assign cnt_x    = CMP_W'(count);
  assign peek_pos = PTR_W'(rp_r[so] + PTR_W'(count));

  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    side_nxt  = side_r;
    ok        = 1'b0;
    rd        = 1'b0;
    req.re    = 1'b0;
    req.we    = 1'b0;
    req.addr  = store_idx(si, wp_r[si]);
    req.wdata = data_in;
    case (func)
      FN_PUT: begin
        if (wp_r[si] < PTR_W'(CAPACITY)) begin
          req.we     = accept;
          wp_nxt[si] = wp_r[si] + 1'b1;
          ok         = 1'b1;
        end
      end
      FN_GET: begin
        req.addr = store_idx(so, rp_r[so]);
        if (held_o != '0) begin
          req.re     = accept;
          rp_nxt[so] = rp_r[so] + 1'b1;
          ok         = 1'b1;
          rd         = 1'b1;
        end
      end
      FN_PEEK: begin
        req.addr = store_idx(so, peek_pos);
        if (cnt_x < CMP_W'(held_o)) begin
          req.re = accept;
          ok     = 1'b1;
          rd     = 1'b1;
        end
      end
      FN_REMOVE_OUT: begin
        if (cnt_x >= CMP_W'(held_o)) begin
          rp_nxt[so] = '0;
          wp_nxt[so] = '0;
        end else begin
          rp_nxt[so] = peek_pos;
        end
      end
      FN_REMOVE_IN: begin
        if (cnt_x >= CMP_W'(held_i)) begin
          rp_nxt[si] = '0;
          wp_nxt[si] = '0;
        end else begin
          rp_nxt[si] = PTR_W'(rp_r[si] + PTR_W'(count));
        end
      end
      FN_CLEAR_OUT: begin
        rp_nxt[so] = '0;
        wp_nxt[so] = '0;
      end
      FN_CLEAR_IN: begin
        rp_nxt[si] = '0;
        wp_nxt[si] = '0;
      end
      FN_FLIP: begin
        if (held_o == '0) begin
          rp_nxt[so] = '0;
          wp_nxt[so] = '0;
          side_nxt   = so;
          ok         = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Fill levels after the step
  assign ui = wp_nxt[side_nxt] - rp_nxt[side_nxt];
  assign uo = wp_nxt[~side_nxt] - rp_nxt[~side_nxt];

  assign res.rd       = rd;
  assign res.ok       = ok;
  assign res.used_in  = CNT_W'(ui);
  assign res.used_out = CNT_W'(uo);
  assign res.free_in  = CNT_W'(PTR_W'(CAPACITY) - ui);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r[0] <= '0;
      rp_r[1] <= '0;
      wp_r[0] <= '0;
      wp_r[1] <= '0;
      side_r  <= 1'b0;
    end else if (accept) begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

// ----- src/ping_pong_byte_buffer.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Payload
// in_ch    | in  | func, data_in, count
// out_ch   | out | data_out, ok, used_in, used_out, free_in
//
// One item per cycle while no result is stalled: an accepted item yields its result in the next cycle.
// The result is registered, and so is the read of the 2*CAPACITY byte store.
// Synchronous active-low reset clears both sides' pointers and the side select.
// The byte store has no reset; only written bytes are ever read.
// A stalled result blocks new input; read data holds until the result transfers.
module ping_pong_byte_buffer
  import ppbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ppbb_in_if.sink    in_ch,
  ppbb_out_if.source out_ch
);

  logic              accept;
  mem_req_t          req;
  step_res_t         res;
  logic [DATA_W-1:0] rdata;

  logic              out_valid_r;
  logic              rd_r;
  logic              ok_r;
  logic [CNT_W-1:0]  used_in_r;
  logic [CNT_W-1:0]  used_out_r;
  logic [CNT_W-1:0]  free_in_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  ppbb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .func    (in_ch.func),
    .data_in (in_ch.data_in),
    .count   (in_ch.count),
    .req     (req),
    .res     (res)
  );

  ppbb_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r       <= res.rd;
      ok_r       <= res.ok;
      used_in_r  <= res.used_in;
      used_out_r <= res.used_out;
      free_in_r  <= res.free_in;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = rd_r ? rdata : '0;
  assign out_ch.ok       = ok_r;
  assign out_ch.used_in  = used_in_r;
  assign out_ch.used_out = used_out_r;
  assign out_ch.free_in  = free_in_r;

endmodule

// ----- src/ppbb_checker.sv -----
`timescale 1ns / 1ps
module ppbb_checker
  import ppbb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] data_out,
  input logic              ok,
  input logic [CNT_W-1:0]  used_in,
  input logic [CNT_W-1:0]  used_out,
  input logic [CNT_W-1:0]  free_in
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every input transfer produces a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_free_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CMP_W'(used_in) + CMP_W'(free_in)) == CMP_W'(CAPACITY))
    else $error("used_in and free_in do not sum to capacity");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CMP_W'(used_in) <= CMP_W'(CAPACITY))
               && (CMP_W'(used_out) <= CMP_W'(CAPACITY)))
    else $error("fill level beyond capacity");

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ok |-> data_out == '0)
    else $error("nonzero data on failed item");

endmodule

bind ping_pong_byte_buffer ppbb_checker u_ppbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_out  (out_ch.data_out),
  .ok        (out_ch.ok),
  .used_in   (out_ch.used_in),
  .used_out  (out_ch.used_out),
  .free_in   (out_ch.free_in)
);

// ----- tb/sv/ping_pong_byte_buffer_checker.sv -----
`timescale 1ns / 1ps
module ping_pong_byte_buffer_checker
  import ppbb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ppbb_in_if   in_ch,
  ppbb_out_if  out_ch,
  output int   mismatch_count,
  output int   replies_due_count
);

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              ok;
    logic [CNT_W-1:0]  used_in;
    logic [CNT_W-1:0]  used_out;
    logic [CNT_W-1:0]  free_in;
  } buf_reply_t;

  // Shadow copy of both sides
  logic [DATA_W-1:0] side_bytes [DEPTH];
  int                rd_pos [2];
  int                wr_pos [2];
  bit                in_side;

  buf_reply_t replies_due [$];
  buf_reply_t due;

  function automatic int held_bytes(bit side);
    return wr_pos[side] - rd_pos[side];
  endfunction

  function automatic void empty_side(bit side);
    rd_pos[side] = 0;
    wr_pos[side] = 0;
  endfunction

  // Discarding at least what is held clears the side
  function automatic void drop_front(bit side, int n);
    if (n >= held_bytes(side)) begin
      empty_side(side);
    end else begin
      rd_pos[side] += n;
    end
  endfunction

  function automatic int slot(bit side, int pos);
    return (int'(side) * CAPACITY + pos) % DEPTH;
  endfunction

  function automatic buf_reply_t apply_command(logic [FUNC_W-1:0] fn,
                                               logic [DATA_W-1:0] byte_in,
                                               logic [CNT_W-1:0]  cnt);
    buf_reply_t r;
    bit         si;
    bit         so;
    int         n;
    r  = '0;
    si = in_side;
    so = ~in_side;
    n  = int'(cnt);
    case (fn)
      FN_PUT: begin
        // partial removes keep the write position: a full side stays full
        if (wr_pos[si] < CAPACITY) begin
          side_bytes[slot(si, wr_pos[si])] = byte_in;
          wr_pos[si]++;
          r.ok = 1'b1;
        end
      end
      FN_GET: begin
        if (held_bytes(so) != 0) begin
          r.data_out = side_bytes[slot(so, rd_pos[so])];
          rd_pos[so]++;
          r.ok = 1'b1;
        end
      end
      FN_PEEK: begin
        if (n < held_bytes(so)) begin
          r.data_out = side_bytes[slot(so, rd_pos[so] + n)];
          r.ok = 1'b1;
        end
      end
      FN_REMOVE_OUT: drop_front(so, n);
      FN_REMOVE_IN:  drop_front(si, n);
      FN_CLEAR_OUT:  empty_side(so);
      FN_CLEAR_IN:   empty_side(si);
      default: begin
        if (held_bytes(so) == 0) begin
          empty_side(so);
          in_side = so;
          r.ok = 1'b1;
        end
      end
    endcase
    r.used_in  = CNT_W'(held_bytes(in_side));
    r.used_out = CNT_W'(held_bytes(~in_side));
    r.free_in  = CNT_W'(CAPACITY - held_bytes(in_side));
    return r;
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_side(1'b0);
      empty_side(1'b1);
      in_side = 1'b0;
      replies_due.delete();
      mismatch_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        replies_due.push_back(apply_command(in_ch.func, in_ch.data_in, in_ch.count));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result transfer with nothing expected, got data_out %0d ok %0d",
                   $time, out_ch.data_out, out_ch.ok);
        end else begin
          due = replies_due.pop_front();
          check_field("data_out", due.data_out, out_ch.data_out);
          check_field("ok",       due.ok,       out_ch.ok);
          check_field("used_in",  due.used_in,  out_ch.used_in);
          check_field("used_out", due.used_out, out_ch.used_out);
          check_field("free_in",  due.free_in,  out_ch.free_in);
        end
      end
    end
    replies_due_count = replies_due.size();
  end

endmodule

// ----- tb/sv/ping_pong_byte_buffer_tb.sv -----
`timescale 1ns / 1ps
module ping_pong_byte_buffer_tb;
  import ppbb_pkg::*;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   mismatch_count;
  int   replies_due_count;
  int   drain_cycles;

  ppbb_in_if  in_ch ();
  ppbb_out_if out_ch ();

  ping_pong_byte_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ping_pong_byte_buffer_checker buf_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .mismatch_count    (mismatch_count),
    .replies_due_count (replies_due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Drop valid through random gaps (with junk payload), then hold it until the transfer
  task automatic send_cmd(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] d,
                          logic [CNT_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.func    <= FUNC_W'($urandom_range(7));
      in_ch.data_in <= DATA_W'($urandom_range(255));
      in_ch.count   <= CNT_W'($urandom_range(2047));
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= fn;
    in_ch.data_in <= d;
    in_ch.count   <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly produce/flip/consume rounds with random content, the rest noise
  task automatic run_phase(int budget, int idle, int stall);
    int sent;
    int burst;
    int k;
    int pick;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 70) begin
        burst = $urandom_range(1, 16);
        for (k = 0; k < burst; k++) begin
          send_cmd(FN_PUT, DATA_W'($urandom_range(255)), CNT_W'($urandom_range(2047)));
        end
        send_cmd(FN_FLIP, DATA_W'($urandom_range(255)), CNT_W'($urandom_range(2047)));
        for (k = 0; k < burst; k++) begin
          pick = $urandom_range(99);
          if (pick < 60) begin
            send_cmd(FN_GET, DATA_W'($urandom_range(255)), CNT_W'($urandom_range(2047)));
          end else if (pick < 85) begin
            send_cmd(FN_PEEK, DATA_W'($urandom_range(255)), CNT_W'($urandom_range(burst)));
          end else begin
            send_cmd(FN_REMOVE_OUT, DATA_W'($urandom_range(255)), CNT_W'($urandom_range(3)));
          end
        end
        sent += 2 * burst + 1;
      end else begin
        if ($urandom_range(1) == 0) begin
          send_cmd(FUNC_W'($urandom_range(7)), DATA_W'($urandom_range(255)),
                   CNT_W'($urandom_range(20)));
        end else begin
          send_cmd(FUNC_W'($urandom_range(7)), DATA_W'($urandom_range(255)),
                   CNT_W'($urandom_range(2047)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FN_PUT;
    in_ch.data_in = '0;
    in_ch.count   = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, flips both ways, peek bounds, removes and clears
    send_cmd(FN_GET,        8'h00, 11'd0);
    send_cmd(FN_PEEK,       8'h00, 11'd0);
    send_cmd(FN_PUT,        8'h00, 11'd0);
    send_cmd(FN_PUT,        8'hFF, 11'd2047);
    send_cmd(FN_PUT,        8'hA5, 11'd0);
    send_cmd(FN_FLIP,       8'h00, 11'd0);
    send_cmd(FN_FLIP,       8'h00, 11'd0);
    send_cmd(FN_PEEK,       8'h00, 11'd2);
    send_cmd(FN_PEEK,       8'h00, 11'd3);
    send_cmd(FN_PEEK,       8'h00, 11'd2047);
    send_cmd(FN_GET,        8'h00, 11'd0);
    send_cmd(FN_REMOVE_OUT, 8'h00, 11'd1);
    send_cmd(FN_GET,        8'h00, 11'd0);
    send_cmd(FN_PUT,        8'h55, 11'd0);
    send_cmd(FN_PUT,        8'hAA, 11'd0);
    send_cmd(FN_REMOVE_IN,  8'h00, 11'd0);
    send_cmd(FN_REMOVE_IN,  8'h00, 11'd1);
    send_cmd(FN_REMOVE_IN,  8'h00, 11'd2047);
    send_cmd(FN_PUT,        8'h3C, 11'd0);
    send_cmd(FN_FLIP,       8'h00, 11'd0);
    send_cmd(FN_REMOVE_OUT, 8'h00, 11'd1024);
    send_cmd(FN_PUT,        8'h81, 11'd0);
    send_cmd(FN_CLEAR_IN,   8'h00, 11'd0);
    send_cmd(FN_PUT,        8'h7E, 11'd0);
    send_cmd(FN_FLIP,       8'h00, 11'd0);
    send_cmd(FN_CLEAR_OUT,  8'h00, 11'd0);
    send_cmd(FN_FLIP,       8'h00, 11'd0);

    // Fill one side to capacity; puts past the end must drop, even after a remove
    send_cmd(FN_CLEAR_IN, 8'h00, 11'd0);
    repeat (CAPACITY + 1) send_cmd(FN_PUT, DATA_W'($urandom_range(255)), '0);
    send_cmd(FN_REMOVE_IN,  8'h00, 11'd5);
    send_cmd(FN_PUT,        8'h99, 11'd0);
    send_cmd(FN_CLEAR_OUT,  8'h00, 11'd0);
    send_cmd(FN_FLIP,       8'h00, 11'd0);
    send_cmd(FN_PEEK,       8'h00, CNT_W'(CAPACITY - 6));
    send_cmd(FN_PEEK,       8'h00, CNT_W'(CAPACITY - 5));
    repeat (3) send_cmd(FN_GET, 8'h00, 11'd0);
    send_cmd(FN_PUT,        8'h42, 11'd0);
    send_cmd(FN_REMOVE_OUT, 8'h00, 11'd1000);
    send_cmd(FN_GET,        8'h00, 11'd0);
    send_cmd(FN_REMOVE_OUT, 8'h00, 11'd2047);
    send_cmd(FN_FLIP,       8'h00, 11'd0);

    run_phase(25, 0, 0);
    run_phase(25, 80, 0);
    run_phase(25, 0, 80);
    run_phase(25, 31, 31);

    in_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (replies_due_count != 0 && drain_cycles < 20000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (10) @(negedge clk);
    if (replies_due_count != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, replies_due_count);
    end
    if (mismatch_count == 0 && replies_due_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- ping_pong_byte_buffer.f -----
src/ppbb_pkg.sv
src/ppbb_if.sv
src/ppbb_mem.sv
src/ppbb_ctrl.sv
src/ping_pong_byte_buffer.sv
src/ppbb_checker.sv
tb/sv/ping_pong_byte_buffer_checker.sv
tb/sv/ping_pong_byte_buffer_tb.sv
